// ===== hw/rtl/cscv_pkg.sv =====
// ----------------------------------------------------------------------------
// cscv_pkg: shared types and constants
// Request payloads, event kinds, error codes and container layout constants
// for the chunked-stream CRC validator.
// ----------------------------------------------------------------------------
`default_nettype none

package cscv_pkg;

  // Container layout
  localparam int FILE_HEADER_BYTES  = 24;
  localparam int CHUNK_HEADER_BYTES = 24;
  localparam int MAGIC_BYTES        = 8;
  localparam int HDR_CRC_BYTES      = FILE_HEADER_BYTES - 4;
  localparam int POS_W              = $clog2(FILE_HEADER_BYTES);

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
  localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

  // Configuration register indexes
  localparam logic CFG_MAGIC  = 1'b0;
  localparam logic CFG_FORMAT = 1'b1;

  // Event kinds
  localparam logic [2:0] EV_HEADER_OK = 3'd0;
  localparam logic [2:0] EV_PAYLOAD   = 3'd1;
  localparam logic [2:0] EV_CHUNK_OK  = 3'd2;
  localparam logic [2:0] EV_CLEAN_END = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_HDR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ERR_HDR_CRC      = 3'd3;
  localparam logic [2:0] ERR_VERSION      = 3'd4;
  localparam logic [2:0] ERR_CHUNK_SHORT  = 3'd5;
  localparam logic [2:0] ERR_PAYLOAD_SHORT = 3'd6;
  localparam logic [2:0] ERR_CHUNK_CRC    = 3'd7;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [2:0]  error_code;
    logic [31:0] block_tag;
    logic [31:0] block_rev;
    logic [63:0] body_length;
    logic [7:0]  payload_byte;
    logic [31:0] host_version;
    logic [31:0] header_flags;
    logic [31:0] computed_crc;
  } out_t;

  // Push controls from the parser to the output queue
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cscv_core.sv =====
// ----------------------------------------------------------------------------
// cscv_core: container parser and CRC checker
// Consumes one request per cycle while acc is high, keeps the header bytes,
// runs CRC-32 and produces up to two results per request for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cscv_core (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              acc,
  input  cscv_pkg::in_t    in_data,
  input  wire              cfg_we,
  input  wire              cfg_index,
  input  wire [63:0]       cfg_wdata,
  output cscv_pkg::push_t  push,
  output cscv_pkg::out_t   res_a,
  output cscv_pkg::out_t   res_b
);
  import cscv_pkg::*;

  typedef enum logic [2:0] {
    PH_FILE_HDR,
    PH_CHUNK_HDR,
    PH_PAYLOAD,
    PH_DONE,
    PH_HALTED
  } phase_t;

  // One byte of reflected CRC-32
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic [63:0]         rem_r, rem_nxt;
  logic [63:0]         hsize_r, hsize_nxt;
  logic [31:0]         hcrc_r, hcrc_nxt;
  logic [63:0]         magic_r;
  logic [31:0]         format_r;
  logic [7:0]          store_r [FILE_HEADER_BYTES];
  logic [7:0]          view    [FILE_HEADER_BYTES];
  logic                store_we;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] crc_b;
  logic [31:0] hdr_fin;
  logic [31:0] pay_fin;
  logic        last_hdr;
  logic        magic_bad;
  logic [31:0] w0, w4, w8, w12, w16, w20;
  logic [31:0] st_id, st_ver;
  logic [63:0] new_size;

  assign b     = in_data.byte_value;
  assign eof   = in_data.end_of_file;
  assign crc_b = crc_step(crc_r, b);

  // Header bytes as they stand once the incoming byte is in place
  always_comb begin
    for (int i = 0; i < FILE_HEADER_BYTES; i++) begin
      view[i] = ((POS_W'(i) == pos_r) && (phase_r != PH_PAYLOAD)) ? b : store_r[i];
    end
  end

  assign w0  = {view[3],  view[2],  view[1],  view[0]};
  assign w4  = {view[7],  view[6],  view[5],  view[4]};
  assign w8  = {view[11], view[10], view[9],  view[8]};
  assign w12 = {view[15], view[14], view[13], view[12]};
  assign w16 = {view[19], view[18], view[17], view[16]};
  assign w20 = {view[23], view[22], view[21], view[20]};
  assign st_id  = {store_r[3], store_r[2], store_r[1], store_r[0]};
  assign st_ver = {store_r[7], store_r[6], store_r[5], store_r[4]};
  assign new_size = {w12, w8};

  assign last_hdr = (pos_r == POS_W'(FILE_HEADER_BYTES - 1));
  assign hdr_fin  = crc_r ^ CRC_ONES;
  assign pay_fin  = crc_b ^ CRC_ONES;

  // Compare the magic bytes against the register
  always_comb begin
    magic_bad = 1'b0;
    for (int i = 0; i < MAGIC_BYTES; i++) begin
      if (view[i] != magic_r[8*i +: 8]) begin
        magic_bad = 1'b1;
      end
    end
  end

  // Parse one request
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    rem_nxt   = rem_r;
    hsize_nxt = hsize_r;
    hcrc_nxt  = hcrc_r;
    store_we  = 1'b0;
    push      = '0;
    res_a     = '0;
    res_b     = '0;
    if (acc) begin
      unique case (phase_r)
        PH_FILE_HDR: begin
          if (eof) begin
            push.push_a      = 1'b1;
            res_a.event_kind = EV_ERROR;
            res_a.error_code = ERR_HDR_SHORT;
            phase_nxt        = PH_HALTED;
          end else begin
            store_we = 1'b1;
            if (pos_r < POS_W'(HDR_CRC_BYTES)) begin
              crc_nxt = crc_b;
            end
            pos_nxt = pos_r + POS_W'(1);
            if (last_hdr) begin
              pos_nxt      = '0;
              push.push_a  = 1'b1;
              phase_nxt    = PH_HALTED;
              res_a.event_kind = EV_ERROR;
              priority if (magic_bad) begin
                res_a.error_code = ERR_BAD_MAGIC;
              end else if (hdr_fin != w20) begin
                res_a.error_code   = ERR_HDR_CRC;
                res_a.computed_crc = hdr_fin;
              end else if (w8 != format_r) begin
                res_a.error_code   = ERR_VERSION;
                res_a.computed_crc = hdr_fin;
              end else begin
                res_a.event_kind   = EV_HEADER_OK;
                res_a.host_version = w12;
                res_a.header_flags = w16;
                res_a.computed_crc = hdr_fin;
                phase_nxt          = PH_CHUNK_HDR;
              end
            end
          end
        end
        PH_CHUNK_HDR: begin
          if (eof) begin
            push.push_a = 1'b1;
            if (pos_r != '0) begin
              res_a.event_kind = EV_ERROR;
              res_a.error_code = ERR_CHUNK_SHORT;
              phase_nxt        = PH_HALTED;
            end else begin
              res_a.event_kind = EV_CLEAN_END;
              phase_nxt        = PH_DONE;
            end
          end else begin
            store_we = 1'b1;
            pos_nxt  = pos_r + POS_W'(1);
            if (pos_r == POS_W'(CHUNK_HEADER_BYTES - 1)) begin
              pos_nxt   = '0;
              hsize_nxt = new_size;
              hcrc_nxt  = w16;
              rem_nxt   = new_size;
              crc_nxt   = CRC_ONES;
              if (new_size == '0) begin
                // Empty payload: judge at once, the final CRC is zero
                push.push_a = 1'b1;
                if (w16 != '0) begin
                  res_a.event_kind = EV_ERROR;
                  res_a.error_code = ERR_CHUNK_CRC;
                  phase_nxt        = PH_HALTED;
                end else begin
                  res_a.event_kind = EV_CHUNK_OK;
                  res_a.block_tag  = w0;
                  res_a.block_rev  = w4;
                end
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          push.push_a = 1'b1;
          if (eof) begin
            res_a.event_kind = EV_ERROR;
            res_a.error_code = ERR_PAYLOAD_SHORT;
            phase_nxt        = PH_HALTED;
          end else begin
            res_a.event_kind   = EV_PAYLOAD;
            res_a.payload_byte = b;
            crc_nxt            = crc_b;
            rem_nxt            = rem_r - 64'd1;
            if (rem_r == 64'd1) begin
              // Last byte: verdict follows the byte
              push.push_b        = 1'b1;
              res_b.computed_crc = pay_fin;
              if (pay_fin != hcrc_r) begin
                res_b.event_kind = EV_ERROR;
                res_b.error_code = ERR_CHUNK_CRC;
                phase_nxt        = PH_HALTED;
              end else begin
                res_b.event_kind  = EV_CHUNK_OK;
                res_b.block_tag   = st_id;
                res_b.block_rev   = st_ver;
                res_b.body_length = hsize_r;
                phase_nxt         = PH_CHUNK_HDR;
              end
            end
          end
        end
        PH_DONE, PH_HALTED: begin
          // drop everything until reset
        end
        default: begin
          phase_nxt = PH_HALTED;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FILE_HDR;
      pos_r    <= '0;
      crc_r    <= CRC_ONES;
      rem_r    <= '0;
      hsize_r  <= '0;
      hcrc_r   <= '0;
      magic_r  <= '0;
      format_r <= 32'd1;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      rem_r   <= rem_nxt;
      hsize_r <= hsize_nxt;
      hcrc_r  <= hcrc_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAGIC:  magic_r  <= cfg_wdata;
          CFG_FORMAT: format_r <= cfg_wdata[31:0];
          default:    magic_r  <= magic_r;
        endcase
      end
    end
  end

  // Header byte store, no reset
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_r] <= b;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cscv_outq.sv =====
// ----------------------------------------------------------------------------
// cscv_outq: result queue
// Small register queue taking up to two results per cycle and handing one per
// cycle to the output unless stalled; flags when two free slots are not there.
// ----------------------------------------------------------------------------
`default_nettype none

module cscv_outq #(
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  cscv_pkg::push_t  push,
  input  cscv_pkg::out_t   res_a,
  input  cscv_pkg::out_t   res_b,
  output logic             no_room,
  output logic             out_valid,
  input  wire              out_stall,
  output cscv_pkg::out_t   out_data
);
  import cscv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  out_t          q_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, wp_b;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign no_room   = (cnt_r > CW'(DEPTH - 2));
  assign wp_b      = inc(wp_r);

  // Advance pointers and count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r - (pop ? CW'(1) : CW'(0));
    if (push.push_a) begin
      wp_nxt  = wp_b;
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (push.push_b) begin
      wp_nxt  = inc(wp_b);
      cnt_nxt = cnt_nxt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      q_r[wp_r] <= res_a;
    end
    if (push.push_b) begin
      q_r[wp_b] <= res_b;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chunk_stream_crc_validator.sv =====
// ----------------------------------------------------------------------------
// chunk_stream_crc_validator: chunked container validator with CRC-32
// Checks the file header and each chunk of a container taken one byte per
// request, passes payload bytes on and reports a verdict per chunk.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one file byte per request,
//   then a request with end_of_file set. Output channel (out_valid /
//   out_stall / out_data): header verdict, payload bytes, chunk verdicts,
//   clean end or one error; after an error or clean end input is dropped.
//   cfg_we / cfg_index / cfg_wdata write magic_value (0) and
//   expected_format (1); write them only while the block is idle.
// Timing:
//   One request per cycle while in_stall is low. Each result is registered in
//   the result queue before it shows on out_valid. The last byte of a payload
//   gives two results (the byte, then the verdict), which leave one after the
//   other through the result queue of OUT_DEPTH entries. in_stall rises when
//   the queue has fewer than two free slots, so throughput is set by the
//   output side: one result per cycle while out_stall is low.
// Reset:
//   Synchronous, active low. Clears the parser, the queue and the registers
//   (magic 0, format 1). A stalled output holds its result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_stream_crc_validator #(
  parameter int OUT_DEPTH = 4
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  cscv_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output cscv_pkg::out_t  out_data,
  input  wire             cfg_we,
  input  wire             cfg_index,
  input  wire [63:0]      cfg_wdata
);
  import cscv_pkg::*;

  logic  acc;
  logic  no_room;
  push_t push;
  out_t  res_a;
  out_t  res_b;

  assign in_stall = no_room;
  assign acc      = in_valid && !no_room;

  cscv_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  cscv_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .no_room   (no_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cscv_chk.sv =====
// ----------------------------------------------------------------------------
// cscv_chk: port checker
// Watches the validator's ports for result consistency and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module cscv_chk (
  input wire             clk,
  input wire             rst_n,
  input wire             out_valid,
  input wire             out_stall,
  input cscv_pkg::out_t  out_data
);
  import cscv_pkg::*;

  // Queue empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An error code goes with an error event and only there
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.event_kind == EV_ERROR) == (out_data.error_code != ERR_NONE)))
    else $error("error code and event kind disagree");

  // Payload byte is zero except on payload events
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind != EV_PAYLOAD) |-> (out_data.payload_byte == 8'd0))
    else $error("payload byte on a non-payload event");

  // Chunk fields are zero except on chunk verdicts
  a_chunk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind != EV_CHUNK_OK)
      |-> (out_data.block_tag == 32'd0) && (out_data.body_length == 64'd0))
    else $error("chunk fields on a non-chunk event");

endmodule

bind chunk_stream_crc_validator cscv_chk u_chk (.*);

`default_nettype wire
